/* rtl/core/mrrd_pkg.sv */
// Shared types and constants for the Modbus RTU response deframer.
// Used by mrrd_crc_byte, mrrd_frame_track and the top level; no dependencies.
package mrrd_pkg;

   localparam int FRAME_BYTES = 21;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int DATA_BYTES  = 16;

   localparam logic [IDX_W-1:0] DATA_FIRST    = IDX_W'(3);
   localparam logic [IDX_W-1:0] DATA_LAST     = IDX_W'(3 + DATA_BYTES - 1);
   localparam logic [IDX_W-1:0] CRC_LOW_INDEX = IDX_W'(FRAME_BYTES - 2);
   localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(FRAME_BYTES - 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_LSB  = 16'h0001;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } in_item_type;

   typedef struct packed {
      logic        [15:0] voltage_raw;
      logic        [15:0] current_raw;
      logic signed [31:0] power_raw;
      logic        [15:0] factor_raw;
      logic        [15:0] frequency_raw;
      logic        [31:0] energy_raw;
      logic               crc_ok;
   } rsp_item_type;

endpackage

/* rtl/core/mrrd_crc_byte.sv */
// Modbus CRC-16 update by one byte, eight reflected shift steps unrolled.
// Depends on mrrd_pkg for the polynomial.
module mrrd_crc_byte
   import mrrd_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   logic [15:0] crc_work;

   always_comb begin
      crc_work = crc_cur ^ {8'h00, data_byte};
      for (int bit_i = 0; bit_i < 8; bit_i++) begin
         if ((crc_work & CRC_LSB) != 16'h0000) begin
            crc_work = (crc_work >> 1) ^ CRC_POLY;
         end else begin
            crc_work = crc_work >> 1;
         end
      end
      crc_next = crc_work;
   end

endmodule

/* rtl/core/mrrd_frame_track.sv */
// Frame position, running CRC and data byte shift line of the deframer.
// Depends on mrrd_pkg and mrrd_crc_byte.
module mrrd_frame_track
   import mrrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  in_item_type  item,
   output logic         is_last,
   output rsp_item_type rsp_item
);

   logic [IDX_W-1:0] index_ff, index_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_low_ff, crc_low_in;
   logic [7:0]       data_ff [DATA_BYTES];
   logic [IDX_W-1:0] idx;
   logic [15:0]      crc_base;
   logic [15:0]      crc_upd;
   logic             shift_en;

   assign idx      = item.frame_start ? '0 : index_ff;
   assign crc_base = item.frame_start ? CRC_INIT : crc_ff;
   assign is_last  = (idx == LAST_INDEX);
   assign shift_en = fire && (idx >= DATA_FIRST) && (idx <= DATA_LAST);

   mrrd_crc_byte u_crc (
      .crc_cur   (crc_base),
      .data_byte (item.rx_byte),
      .crc_next  (crc_upd)
   );

   always_comb begin
      index_in   = index_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      if (fire) begin
         priority if (idx < CRC_LOW_INDEX) begin
            crc_in   = crc_upd;
            index_in = idx + IDX_W'(1);
         end else if (idx == CRC_LOW_INDEX) begin
            crc_low_in = item.rx_byte;
            crc_in     = crc_base;
            index_in   = idx + IDX_W'(1);
         end else begin
            // frame done: restart for the next byte
            crc_in   = CRC_INIT;
            index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= 8'h00;
      end else begin
         index_ff   <= index_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

   // data bytes enter at the top; at the last byte slot 0 holds frame byte 3
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < DATA_BYTES - 1; i++) begin
            data_ff[i] <= data_ff[i+1];
         end
         data_ff[DATA_BYTES-1] <= item.rx_byte;
      end
   end

   always_comb begin
      rsp_item.voltage_raw   = {data_ff[0], data_ff[1]};
      rsp_item.current_raw   = {data_ff[2], data_ff[3]};
      rsp_item.power_raw     = {data_ff[4], data_ff[5], data_ff[6], data_ff[7]};
      rsp_item.factor_raw    = {data_ff[8], data_ff[9]};
      rsp_item.frequency_raw = {data_ff[10], data_ff[11]};
      rsp_item.energy_raw    = {data_ff[12], data_ff[13], data_ff[14], data_ff[15]};
      rsp_item.crc_ok        = (crc_low_ff == crc_ff[7:0]) &&
                               (item.rx_byte == crc_ff[15:8]);
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= LAST_INDEX)
      else $error("frame index out of range");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && is_last |=> index_ff == '0 && crc_ff == CRC_INIT)
      else $error("frame state not restarted after last byte");

   a_crc_low_holds: assert property (@(posedge clock) disable iff (reset)
      fire && !item.frame_start && index_ff == CRC_LOW_INDEX |=> crc_ff == $past(crc_ff))
      else $error("running CRC changed on received CRC byte");

endmodule

/* rtl/core/modbus_rtu_response_deframer.sv */
// Top level of the Modbus RTU read-holding-registers response deframer.
// Depends on mrrd_pkg and mrrd_frame_track.
//
//  Channel | Direction | Content
//  req_    | in        | tdata: rx_byte[7:0]; tuser: frame_start
//  rsp_    | out       | tdata: 128-bit register fields; tuser: crc_ok
//
//  One byte per cycle while the input does not stall: each byte is held in the
//  input register, where the CRC byte update and frame position logic act on it,
//  and a result is loaded into the output register when the last byte fires.
//  Reset is synchronous and clears the frame position, CRC and both valids.
//  The input stalls only when the last byte waits while a result is still
//  not taken; all other bytes flow regardless of rsp_tready.
module modbus_rtu_response_deframer
   import mrrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // voltage_raw, current_raw, power_raw,
                                     // factor_raw, frequency_raw, energy_raw
   output logic         rsp_tuser    // [0] crc_ok
);

   logic         in_valid_ff, in_valid_in;
   in_item_type  in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_next;
   logic         is_last;
   logic         out_free;
   logic         fire;
   logic         req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && (!is_last || out_free);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   mrrd_frame_track u_track (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_item_ff),
      .is_last  (is_last),
      .rsp_item (rsp_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.rx_byte     <= req_tdata;
         in_item_ff.frame_start <= req_tuser;
      end
      if (fire && is_last) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.energy_raw, rsp_ff.frequency_raw, rsp_ff.factor_raw,
                        rsp_ff.power_raw, rsp_ff.current_raw, rsp_ff.voltage_raw};
   assign rsp_tuser  = rsp_ff.crc_ok;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && is_last && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && is_last))
      else $error("result raised without a last byte");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("waiting result changed or dropped");

endmodule
